@@ rtl/lscf_pkg.sv @@
`default_nettype none

package lscf_pkg;

	// Datapath width of the fit engine and its fixed constants.
	localparam int WW = 128;
	localparam int SQW = 64;
	localparam int DEF_MAX_POINTS = 32;
	localparam int DEF_COORD_BITS = 12;
	localparam int XIN_W = 12;
	localparam int CXW = 19;
	localparam int RADW = 18;
	localparam int FAR_BIT = 23;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FEW   = 2'd1,
		ST_DEGEN = 2'd2,
		ST_OVF   = 2'd3
	} fit_status_t;

	typedef enum logic [2:0] {
		OP_MAC  = 3'd0,
		OP_DIV  = 3'd1,
		OP_SQRT = 3'd2,
		OP_TST  = 3'd3,
		OP_END  = 3'd4
	} op_kind_t;

	localparam int RF_DEPTH = 20;
	localparam int RF_AW = 5;
	localparam int SRC_W = 6;

	// Scratch register indexes.
	localparam logic [RF_AW-1:0] R_T = 5'd0;
	localparam logic [RF_AW-1:0] R_C = 5'd1;
	localparam logic [RF_AW-1:0] R_D = 5'd2;
	localparam logic [RF_AW-1:0] R_G = 5'd3;
	localparam logic [RF_AW-1:0] R_E = 5'd4;
	localparam logic [RF_AW-1:0] R_H = 5'd5;
	localparam logic [RF_AW-1:0] R_DEN = 5'd6;
	localparam logic [RF_AW-1:0] R_PX = 5'd7;
	localparam logic [RF_AW-1:0] R_PY = 5'd8;
	localparam logic [RF_AW-1:0] R_NX = 5'd9;
	localparam logic [RF_AW-1:0] R_NY = 5'd10;
	localparam logic [RF_AW-1:0] R_XQ = 5'd11;
	localparam logic [RF_AW-1:0] R_YQ = 5'd12;
	localparam logic [RF_AW-1:0] R_X9 = 5'd13;
	localparam logic [RF_AW-1:0] R_Y9 = 5'd14;
	localparam logic [RF_AW-1:0] R_QQ = 5'd15;
	localparam logic [RF_AW-1:0] R_S = 5'd16;
	localparam logic [RF_AW-1:0] R_N256 = 5'd17;
	localparam logic [RF_AW-1:0] R_V = 5'd18;
	localparam logic [RF_AW-1:0] R_RAD = 5'd19;

	// Operand source codes: fixed sources below 32, scratch registers at 32 and above.
	localparam logic [SRC_W-1:0] F_N = 6'd0;
	localparam logic [SRC_W-1:0] F_SX = 6'd1;
	localparam logic [SRC_W-1:0] F_SY = 6'd2;
	localparam logic [SRC_W-1:0] F_SXX = 6'd3;
	localparam logic [SRC_W-1:0] F_SYY = 6'd4;
	localparam logic [SRC_W-1:0] F_SXY = 6'd5;
	localparam logic [SRC_W-1:0] F_SXXX = 6'd6;
	localparam logic [SRC_W-1:0] F_SYYY = 6'd7;
	localparam logic [SRC_W-1:0] F_SXYY = 6'd8;
	localparam logic [SRC_W-1:0] F_SXXY = 6'd9;
	localparam logic [SRC_W-1:0] F_ONE = 6'd10;
	localparam logic [SRC_W-1:0] F_K128 = 6'd11;
	localparam logic [SRC_W-1:0] F_K256 = 6'd12;
	localparam logic [SRC_W-1:0] F_K512 = 6'd13;
	localparam logic [SRC_W-1:0] F_K65536 = 6'd14;

	localparam logic [SRC_W-1:0] A_T = {1'b1, R_T};
	localparam logic [SRC_W-1:0] A_C = {1'b1, R_C};
	localparam logic [SRC_W-1:0] A_D = {1'b1, R_D};
	localparam logic [SRC_W-1:0] A_G = {1'b1, R_G};
	localparam logic [SRC_W-1:0] A_E = {1'b1, R_E};
	localparam logic [SRC_W-1:0] A_H = {1'b1, R_H};
	localparam logic [SRC_W-1:0] A_DEN = {1'b1, R_DEN};
	localparam logic [SRC_W-1:0] A_PX = {1'b1, R_PX};
	localparam logic [SRC_W-1:0] A_PY = {1'b1, R_PY};
	localparam logic [SRC_W-1:0] A_NX = {1'b1, R_NX};
	localparam logic [SRC_W-1:0] A_NY = {1'b1, R_NY};
	localparam logic [SRC_W-1:0] A_XQ = {1'b1, R_XQ};
	localparam logic [SRC_W-1:0] A_YQ = {1'b1, R_YQ};
	localparam logic [SRC_W-1:0] A_X9 = {1'b1, R_X9};
	localparam logic [SRC_W-1:0] A_Y9 = {1'b1, R_Y9};
	localparam logic [SRC_W-1:0] A_QQ = {1'b1, R_QQ};
	localparam logic [SRC_W-1:0] A_S = {1'b1, R_S};
	localparam logic [SRC_W-1:0] A_N256 = {1'b1, R_N256};
	localparam logic [SRC_W-1:0] A_V = {1'b1, R_V};

	typedef struct packed {
		op_kind_t          kind;
		logic              clr;
		logic              neg;
		logic [SRC_W-1:0]  a;
		logic [SRC_W-1:0]  b;
		logic              wr;
		logic [RF_AW-1:0]  dst;
	} uop_t;

	localparam int PC_W = 6;

	function automatic uop_t mk(op_kind_t kind, logic clr, logic neg, logic [SRC_W-1:0] a,
			logic [SRC_W-1:0] b, logic wr, logic [RF_AW-1:0] dst);
		uop_t u;
		u.kind = kind;
		u.clr = clr;
		u.neg = neg;
		u.a = a;
		u.b = b;
		u.wr = wr;
		u.dst = dst;
		return u;
	endfunction

	// Fit program. A multiply step adds or subtracts a*b into the accumulator.
	function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			6'd0: u = mk(OP_MAC, 1'b1, 1'b0, F_SXX, F_ONE, 1'b0, R_T);
			6'd1: u = mk(OP_MAC, 1'b0, 1'b0, F_SYY, F_ONE, 1'b1, R_T);
			6'd2: u = mk(OP_MAC, 1'b1, 1'b0, F_N, F_SXX, 1'b0, R_C);
			6'd3: u = mk(OP_MAC, 1'b0, 1'b1, F_SX, F_SX, 1'b1, R_C);
			6'd4: u = mk(OP_MAC, 1'b1, 1'b0, F_N, F_SXY, 1'b0, R_D);
			6'd5: u = mk(OP_MAC, 1'b0, 1'b1, F_SX, F_SY, 1'b1, R_D);
			6'd6: u = mk(OP_MAC, 1'b1, 1'b0, F_N, F_SYY, 1'b0, R_G);
			6'd7: u = mk(OP_MAC, 1'b0, 1'b1, F_SY, F_SY, 1'b1, R_G);
			6'd8: u = mk(OP_MAC, 1'b1, 1'b0, F_N, F_SXXX, 1'b0, R_E);
			6'd9: u = mk(OP_MAC, 1'b0, 1'b0, F_N, F_SXYY, 1'b0, R_E);
			6'd10: u = mk(OP_MAC, 1'b0, 1'b1, A_T, F_SX, 1'b1, R_E);
			6'd11: u = mk(OP_MAC, 1'b1, 1'b0, F_N, F_SXXY, 1'b0, R_H);
			6'd12: u = mk(OP_MAC, 1'b0, 1'b0, F_N, F_SYYY, 1'b0, R_H);
			6'd13: u = mk(OP_MAC, 1'b0, 1'b1, A_T, F_SY, 1'b1, R_H);
			6'd14: u = mk(OP_MAC, 1'b1, 1'b0, A_C, A_G, 1'b0, R_DEN);
			6'd15: u = mk(OP_MAC, 1'b0, 1'b1, A_D, A_D, 1'b1, R_DEN);
			6'd16: u = mk(OP_TST, 1'b0, 1'b0, A_DEN, F_ONE, 1'b0, R_T);
			6'd17: u = mk(OP_MAC, 1'b1, 1'b0, A_E, A_G, 1'b0, R_PX);
			6'd18: u = mk(OP_MAC, 1'b0, 1'b1, A_H, A_D, 1'b1, R_PX);
			6'd19: u = mk(OP_MAC, 1'b1, 1'b0, A_H, A_C, 1'b0, R_PY);
			6'd20: u = mk(OP_MAC, 1'b0, 1'b1, A_E, A_D, 1'b1, R_PY);
			6'd21: u = mk(OP_MAC, 1'b1, 1'b0, A_PX, F_K128, 1'b1, R_NX);
			6'd22: u = mk(OP_MAC, 1'b1, 1'b0, A_PY, F_K128, 1'b1, R_NY);
			6'd23: u = mk(OP_DIV, 1'b0, 1'b0, A_NX, A_DEN, 1'b1, R_XQ);
			6'd24: u = mk(OP_DIV, 1'b0, 1'b0, A_NY, A_DEN, 1'b1, R_YQ);
			6'd25: u = mk(OP_MAC, 1'b1, 1'b0, A_XQ, F_K512, 1'b1, R_X9);
			6'd26: u = mk(OP_MAC, 1'b1, 1'b0, A_YQ, F_K512, 1'b1, R_Y9);
			6'd27: u = mk(OP_MAC, 1'b1, 1'b0, A_XQ, A_XQ, 1'b0, R_QQ);
			6'd28: u = mk(OP_MAC, 1'b0, 1'b0, A_YQ, A_YQ, 1'b1, R_QQ);
			6'd29: u = mk(OP_MAC, 1'b1, 1'b0, A_T, F_K65536, 1'b0, R_S);
			6'd30: u = mk(OP_MAC, 1'b0, 1'b1, A_X9, F_SX, 1'b0, R_S);
			6'd31: u = mk(OP_MAC, 1'b0, 1'b1, A_Y9, F_SY, 1'b0, R_S);
			6'd32: u = mk(OP_MAC, 1'b0, 1'b0, F_N, A_QQ, 1'b1, R_S);
			6'd33: u = mk(OP_MAC, 1'b1, 1'b0, F_N, F_K256, 1'b1, R_N256);
			6'd34: u = mk(OP_DIV, 1'b0, 1'b0, A_S, A_N256, 1'b1, R_V);
			6'd35: u = mk(OP_SQRT, 1'b0, 1'b0, A_V, F_ONE, 1'b1, R_RAD);
			default: u = mk(OP_END, 1'b0, 1'b0, F_ONE, F_ONE, 1'b0, R_T);
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

@@ rtl/least_squares_circle_fit_core.sv @@
`default_nettype none

// Channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// input     | in_valid / in_stall  | x_coord, y_coord, last_point
// output    | out_valid / out_stall| fit_status, center_x, center_y, circle_radius
//
// A point request passes through the square, cube and add states and back to
// idle; a point that finds the store full is not stored but flagged, and if it
// carries last_point the fit starts and reports the overflow. Otherwise a request
// with last_point goes straight to the output with fewer than three points, or
// runs the fit program: 37 steps on 128-bit multiply-accumulate, divide and
// square-root units. A multiply step works through the bits of its second operand
// one by one, and a fit stops at the determinant test when that is not positive.
// Reset clears the sums, the count and all control state at once.
// in_stall is high whenever the core is not idle. A finished result sits in the
// output register while out_stall is high; the next set can be gathered meanwhile.

module least_squares_circle_fit_core
	import lscf_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [XIN_W-1:0]       x_coord,
	input  logic [XIN_W-1:0]       y_coord,
	input  logic                   last_point,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             fit_status,
	output logic signed [CXW-1:0]  center_x,
	output logic signed [CXW-1:0]  center_y,
	output logic [RADW-1:0]        circle_radius
);

	localparam int CB = COORD_BITS;
	localparam int NB = $clog2(MAX_POINTS + 1);
	localparam int XW = (CB > XIN_W) ? CB : XIN_W;
	localparam int S1W = CB + NB;
	localparam int S2W = 2 * CB + NB;
	localparam int S3W = 3 * CB + NB;
	localparam int DCW = $clog2(WW);

	typedef enum logic [12:0] {
		S_IDLE   = 13'h0001,
		S_SQ     = 13'h0002,
		S_CUBE   = 13'h0004,
		S_ADD    = 13'h0008,
		S_FSTART = 13'h0010,
		S_RDA    = 13'h0020,
		S_RDB    = 13'h0040,
		S_LOAD   = 13'h0080,
		S_MUL    = 13'h0100,
		S_DIV    = 13'h0200,
		S_DIVFIX = 13'h0400,
		S_SQRT   = 13'h0800,
		S_OUT    = 13'h1000
	} state_t;

	state_t state_q;

	// Point pipeline registers.
	logic [CB-1:0]   x_q, y_q;
	logic            last_q;
	logic [2*CB-1:0] xx_q, yy_q, xy_q;
	logic [3*CB-1:0] xxx_q, yyy_q, xyy_q, xxy_q;

	// Power sums and point count.
	logic [S1W-1:0] sx_q, sy_q;
	logic [S2W-1:0] sxx_q, syy_q, sxy_q;
	logic [S3W-1:0] sxxx_q, syyy_q, sxyy_q, sxxy_q;
	logic [NB-1:0]  cnt_q;
	logic           ovf_q;

	// Sequencer and scratch memory.
	logic [PC_W-1:0]  pc_q;
	uop_t             uop;
	logic [WW-1:0]    rf_mem [RF_DEPTH];
	logic [WW-1:0]    rf_rd_q, fix_q, fix_val, rdata, opa_q;
	logic             fix_sel_q;
	logic [SRC_W-1:0] ra;

	// Shared arithmetic unit state.
	logic [WW-1:0]  mcand_q, mplier_q, prod_q, acc_q, mac_sum;
	logic           mneg_q;
	logic [WW-1:0]  rem_q, quo_q, dden_q, div_res;
	logic           dneg_q;
	logic [DCW-1:0] dcnt_q;
	logic [WW:0]    rem_sh, rem_nx;
	logic           div_ge;
	logic [SQW-1:0] sv_q, sres_q, sbit_q, strial;
	logic           sq_ge;

	logic             wr_en;
	logic [WW-1:0]    wr_data;
	logic [WW-1:0]    wr_shift;

	// Result captures and output registers.
	logic [CXW-1:0]  cx_cap_q, cy_cap_q;
	logic            farx_q, fary_q, sneg_q;
	logic [RADW-1:0] rad_cap_q;
	fit_status_t     res_status_q;

	logic            out_valid_q;
	fit_status_t     fit_status_q;
	logic [CXW-1:0]  center_x_q, center_y_q;
	logic [RADW-1:0] radius_q;
	logic            out_load;
	logic [XW-1:0]   x_ext, y_ext;

	function automatic logic [WW-1:0] abs_w(logic [WW-1:0] v);
		return v[WW-1] ? (~v + WW'(1)) : v;
	endfunction

	// Signed saturation of a 128-bit value to the centre width.
	function automatic logic [CXW-1:0] sat_c(logic [WW-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones = &v[WW-1:CXW-1];
		hi_zeros = ~|v[WW-1:CXW-1];
		if (hi_ones || hi_zeros)
			return v[CXW-1:0];
		else if (v[WW-1])
			return {1'b1, {(CXW-1){1'b0}}};
		else
			return {1'b0, {(CXW-1){1'b1}}};
	endfunction

	// True when the Q.8 centre coordinate is at or beyond the far limit.
	function automatic logic far_c(logic [WW-1:0] v);
		if (v[WW-1])
			return !((&v[WW-1:FAR_BIT]) && (|v[FAR_BIT-1:0]));
		else
			return |v[WW-1:FAR_BIT];
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign fit_status = fit_status_q;
	assign center_x = center_x_q;
	assign center_y = center_y_q;
	assign circle_radius = radius_q;

	assign x_ext = XW'(x_coord);
	assign y_ext = XW'(y_coord);
	assign uop = prog_rom(pc_q);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Operand A is read in the S_RDA state, operand B in the S_RDB state.
	assign ra = (state_q == S_RDA) ? uop.a : uop.b;

	always_comb begin
		unique case (ra)
			F_N:      fix_val = WW'(cnt_q);
			F_SX:     fix_val = WW'(sx_q);
			F_SY:     fix_val = WW'(sy_q);
			F_SXX:    fix_val = WW'(sxx_q);
			F_SYY:    fix_val = WW'(syy_q);
			F_SXY:    fix_val = WW'(sxy_q);
			F_SXXX:   fix_val = WW'(sxxx_q);
			F_SYYY:   fix_val = WW'(syyy_q);
			F_SXYY:   fix_val = WW'(sxyy_q);
			F_SXXY:   fix_val = WW'(sxxy_q);
			F_ONE:    fix_val = WW'(1);
			F_K128:   fix_val = WW'(128);
			F_K256:   fix_val = WW'(256);
			F_K512:   fix_val = WW'(512);
			F_K65536: fix_val = WW'(65536);
			default:  fix_val = '0;
		endcase
	end

	assign rdata = fix_sel_q ? fix_q : rf_rd_q;

	// Adders for accumulate, restoring divide and square root.
	assign mac_sum = mneg_q ? (acc_q - prod_q) : (acc_q + prod_q);
	assign rem_sh = {rem_q, quo_q[WW-1]};
	assign div_ge = (rem_sh >= {1'b0, dden_q});
	assign rem_nx = div_ge ? (rem_sh - {1'b0, dden_q}) : rem_sh;
	// Floor for a negative numerator: -(q + 1) is ~q when the remainder is nonzero.
	assign div_res = !dneg_q ? quo_q : ((rem_q != '0) ? ~quo_q : (~quo_q + WW'(1)));
	assign strial = sres_q + sbit_q;
	assign sq_ge = (sv_q >= strial);

	always_comb begin
		wr_en = 1'b0;
		wr_data = mac_sum;
		priority if (state_q == S_MUL) begin
			wr_en = (mplier_q == '0) && uop.wr;
			wr_data = mac_sum;
		end else if (state_q == S_DIVFIX) begin
			wr_en = 1'b1;
			wr_data = div_res;
		end else if (state_q == S_SQRT) begin
			wr_en = (sbit_q == '0);
			wr_data = WW'(sres_q);
		end
	end

	assign wr_shift = $signed(wr_data) >>> 4;

	always_ff @(posedge clk) begin
		if (wr_en)
			rf_mem[uop.dst] <= wr_data;
		rf_rd_q <= rf_mem[ra[RF_AW-1:0]];
		fix_q <= fix_val;
		fix_sel_q <= !ra[SRC_W-1];
	end

	// Control state and the power sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			sxxx_q <= '0;
			syyy_q <= '0;
			sxyy_q <= '0;
			sxxy_q <= '0;
		end else begin
			// A held result stays until taken; a new one is loaded in S_OUT.
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cnt_q < NB'(MAX_POINTS)) begin
							state_q <= S_SQ;
						end else begin
							ovf_q <= 1'b1;
							if (last_point)
								state_q <= S_FSTART;
						end
					end
				end
				S_SQ: state_q <= S_CUBE;
				S_CUBE: state_q <= S_ADD;
				S_ADD: begin
					sx_q <= sx_q + S1W'(x_q);
					sy_q <= sy_q + S1W'(y_q);
					sxx_q <= sxx_q + S2W'(xx_q);
					syy_q <= syy_q + S2W'(yy_q);
					sxy_q <= sxy_q + S2W'(xy_q);
					sxxx_q <= sxxx_q + S3W'(xxx_q);
					syyy_q <= syyy_q + S3W'(yyy_q);
					sxyy_q <= sxyy_q + S3W'(xyy_q);
					sxxy_q <= sxxy_q + S3W'(xxy_q);
					cnt_q <= cnt_q + NB'(1);
					state_q <= last_q ? S_FSTART : S_IDLE;
				end
				S_FSTART: begin
					pc_q <= '0;
					if (ovf_q || (cnt_q < NB'(3)))
						state_q <= S_OUT;
					else
						state_q <= S_RDA;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_LOAD;
				S_LOAD: begin
					unique case (uop.kind)
						OP_MAC: state_q <= S_MUL;
						OP_DIV: state_q <= S_DIV;
						OP_SQRT: state_q <= S_SQRT;
						OP_TST: begin
							if (opa_q[WW-1] || (opa_q == '0)) begin
								state_q <= S_OUT;
							end else begin
								pc_q <= pc_q + PC_W'(1);
								state_q <= S_RDA;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_MUL: begin
					if (mplier_q == '0) begin
						pc_q <= pc_q + PC_W'(1);
						state_q <= S_RDA;
					end
				end
				S_DIV: begin
					if (dcnt_q == DCW'(WW - 1))
						state_q <= S_DIVFIX;
				end
				S_DIVFIX: begin
					pc_q <= pc_q + PC_W'(1);
					state_q <= S_RDA;
				end
				S_SQRT: begin
					if (sbit_q == '0) begin
						pc_q <= pc_q + PC_W'(1);
						state_q <= S_RDA;
					end
				end
				S_OUT: begin
					if (out_load) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						sx_q <= '0;
						sy_q <= '0;
						sxx_q <= '0;
						syy_q <= '0;
						sxy_q <= '0;
						sxxx_q <= '0;
						syyy_q <= '0;
						sxyy_q <= '0;
						sxxy_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			x_q <= x_ext[CB-1:0];
			y_q <= y_ext[CB-1:0];
			last_q <= last_point;
		end
		if (state_q == S_SQ) begin
			xx_q <= x_q * x_q;
			yy_q <= y_q * y_q;
			xy_q <= x_q * y_q;
		end
		if (state_q == S_CUBE) begin
			xxx_q <= xx_q * x_q;
			yyy_q <= yy_q * y_q;
			xyy_q <= yy_q * x_q;
			xxy_q <= xx_q * y_q;
		end
		if (state_q == S_FSTART)
			res_status_q <= ovf_q ? ST_OVF : ST_FEW;
		if (state_q == S_RDB)
			opa_q <= rdata;
		if (state_q == S_LOAD) begin
			unique case (uop.kind)
				OP_MAC: begin
					mcand_q <= abs_w(opa_q);
					mplier_q <= abs_w(rdata);
					prod_q <= '0;
					mneg_q <= uop.neg ^ opa_q[WW-1] ^ rdata[WW-1];
					if (uop.clr)
						acc_q <= '0;
				end
				OP_DIV: begin
					rem_q <= '0;
					quo_q <= abs_w(opa_q);
					dden_q <= rdata;
					dneg_q <= opa_q[WW-1];
					dcnt_q <= '0;
				end
				OP_SQRT: begin
					sv_q <= opa_q[SQW-1:0];
					sres_q <= '0;
					sbit_q <= SQW'(1) << (SQW - 2);
				end
				OP_TST: res_status_q <= ST_DEGEN;
				default: res_status_q <= ST_OK;
			endcase
		end
		if (state_q == S_MUL) begin
			if (mplier_q != '0) begin
				if (mplier_q[0])
					prod_q <= prod_q + mcand_q;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end else begin
				acc_q <= mac_sum;
			end
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_nx[WW-1:0];
			quo_q <= {quo_q[WW-2:0], div_ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if ((state_q == S_SQRT) && (sbit_q != '0)) begin
			if (sq_ge) begin
				sv_q <= sv_q - strial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		// The Q.8 centre gives the Q.4 centre by a further floor shift of four.
		if (wr_en && (uop.dst == R_XQ)) begin
			cx_cap_q <= sat_c(wr_shift);
			farx_q <= far_c(wr_data);
		end
		if (wr_en && (uop.dst == R_YQ)) begin
			cy_cap_q <= sat_c(wr_shift);
			fary_q <= far_c(wr_data);
		end
		if (wr_en && (uop.dst == R_S))
			sneg_q <= wr_data[WW-1];
		if (wr_en && (uop.dst == R_RAD))
			rad_cap_q <= (|wr_data[WW-1:RADW]) ? '1 : wr_data[RADW-1:0];
		if (out_load) begin
			fit_status_q <= res_status_q;
			if (res_status_q == ST_OK) begin
				center_x_q <= cx_cap_q;
				center_y_q <= cy_cap_q;
				if (farx_q || fary_q)
					radius_q <= '1;
				else if (sneg_q)
					radius_q <= '0;
				else
					radius_q <= rad_cap_q;
			end else begin
				center_x_q <= '0;
				center_y_q <= '0;
				radius_q <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NB'(MAX_POINTS))
		else $error("point count beyond capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (fit_status_q != ST_OK)) |->
		(center_x_q == '0 && center_y_q == '0 && radius_q == '0))
		else $error("failed fit carries nonzero fields");

	a_store_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (cnt_q == '0 && !ovf_q && sx_q == '0 && out_valid_q))
		else $error("store not cleared after a fit");

	a_div_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (!dden_q[WW-1] && dden_q != '0))
		else $error("divide started with a non-positive divisor");
`endif

endmodule

`default_nettype wire
